// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/tkot_pkg.sv =====
// Shared types and constants of the top-k object tracker.
// No dependencies.
`timescale 1ns / 1ps
package tkot_pkg;
    localparam int TopDepthDefault   = 16;
    localparam int ClassSlotsDefault = 1024;
    localparam int SizeW  = 48;
    localparam int TagW   = 64;
    localparam int ClassW = 10;
    localparam int CountW = 32;
    localparam int BytesW = 56;
    localparam int SeenW  = 40;
    localparam int LimitW = 5;
    localparam int RankW  = 4;
    localparam int KindW  = 2;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 10;

    localparam logic [KindW-1:0] KIND_RECORD = 2'd0;
    localparam logic [KindW-1:0] KIND_REPORT = 2'd1;
    localparam logic [KindW-1:0] KIND_READ   = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_OBJECT_LIMIT = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_CLASS_MAX    = 1'd1;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [ClassW-1:0] cls_id;
        logic [SizeW-1:0]  object_size;
        logic [TagW-1:0]   obj_tag;
    } in_word_t;

    typedef struct packed {
        logic              entry_valid;
        logic [RankW-1:0]  rank;
        logic [SizeW-1:0]  entry_size;
        logic [TagW-1:0]   entry_tag;
        logic [ClassW-1:0] entry_class;
        logic [CountW-1:0] inst_count;
        logic [BytesW-1:0] byte_total;
        logic [SeenW-1:0]  objects_total;
        logic              last;
    } out_word_t;

    typedef struct packed {
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } cfg_word_t;

    typedef struct packed {
        logic [SizeW-1:0]  size;
        logic [TagW-1:0]   tag;
        logic [ClassW-1:0] cls;
    } top_entry_t;
endpackage

// ===== rtl/tkot_if.sv =====
// Valid/ready channel interfaces carrying one word.
// Depends on tkot_pkg.
`timescale 1ns / 1ps
interface tkot_in_if;
    import tkot_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tkot_out_if;
    import tkot_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tkot_cfg_if;
    import tkot_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tkot_hist.sv =====
// Per-class histogram: two synchronous memories, read-modify-write,
// clearing pass after reset. Depends on tkot_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tkot_hist #(
    parameter int CLASS_SLOTS = tkot_pkg::ClassSlotsDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(CLASS_SLOTS)-1:0] rd_addr,
    input  logic                        upd_en,
    input  logic [tkot_pkg::SizeW-1:0]  upd_size,
    output logic [tkot_pkg::CountW-1:0] rd_count,
    output logic [tkot_pkg::BytesW-1:0] rd_bytes,
    output logic                        busy
);
    import tkot_pkg::*;
    localparam int AW = $clog2(CLASS_SLOTS);

    logic [CountW-1:0] count_mem [CLASS_SLOTS];
    logic [BytesW-1:0] bytes_mem [CLASS_SLOTS];
    logic [AW-1:0]     addr_reg;
    logic [AW:0]       clr_reg;
    logic [CountW-1:0] cnt_next;
    logic [BytesW-1:0] byt_next;
    logic [BytesW:0]   sum;

    assign busy = !clr_reg[AW];

    // saturating update of the word read last cycle
    always_comb
    begin
        cnt_next = (rd_count == '1) ? rd_count : rd_count + 1'b1;
        sum = {1'b0, rd_bytes} + {{(BytesW+1-SizeW){1'b0}}, upd_size};
        byt_next = sum[BytesW] ? '1 : sum[BytesW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (busy)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            count_mem[clr_reg[AW-1:0]] <= '0;
            bytes_mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (upd_en)
        begin
            count_mem[addr_reg] <= cnt_next;
            bytes_mem[addr_reg] <= byt_next;
        end
        if (rd_en)
        begin
            rd_count <= count_mem[rd_addr];
            rd_bytes <= bytes_mem[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    `ASSERT_NEVER(a_no_access_clearing, clk, rst_n, busy && (rd_en || upd_en))
    `ASSERT_IMPL(a_upd_after_read, clk, rst_n, upd_en |-> $past(rd_en))
    `ASSERT_NEVER(a_no_back_to_back_rd, clk, rst_n, rd_en && $past(rd_en))
endmodule

// ===== rtl/tkot_list.sv =====
// Sorted list of the largest objects: registers with parallel
// compare-and-shift insert. Depends on tkot_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tkot_list #(
    parameter int TOP_DEPTH = tkot_pkg::TopDepthDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ins_en,
    input  logic [tkot_pkg::LimitW-1:0] object_limit,
    input  tkot_pkg::top_entry_t        ins_entry,
    input  logic [$clog2(TOP_DEPTH+1)-1:0] rd_idx,
    output tkot_pkg::top_entry_t        rd_entry,
    output logic [$clog2(TOP_DEPTH+1)-1:0] fill
);
    import tkot_pkg::*;
    localparam int FW = $clog2(TOP_DEPTH + 1);
    localparam int LW = (FW > LimitW) ? FW : LimitW;

    top_entry_t      list_reg [TOP_DEPTH];
    top_entry_t      list_next [TOP_DEPTH];
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic [LW-1:0]   lim;
    logic            grow;
    logic            repl;
    logic [TOP_DEPTH-1:0] gt;

    assign fill = fill_reg;
    assign rd_entry = list_reg[rd_idx[$clog2(TOP_DEPTH)-1+((TOP_DEPTH==1)?1:0):0]];

    always_comb
    begin
        if (LW'(object_limit) > LW'(TOP_DEPTH))
            lim = LW'(TOP_DEPTH);
        else
            lim = LW'(object_limit);
        grow = (lim != '0) && (LW'(fill_reg) < lim);
        repl = (lim != '0) && !grow && (fill_reg != '0)
            && (ins_entry.size > list_reg[0].size);
        for (int i = 0; i < TOP_DEPTH; i++)
            gt[i] = list_reg[i].size > ins_entry.size;
        list_next = list_reg;
        fill_next = fill_reg;
        if (ins_en && grow)
        begin
            for (int i = 0; i < TOP_DEPTH; i++)
            begin
                if (FW'(i) < fill_reg)
                begin
                    if (gt[i] && i + 1 < TOP_DEPTH)
                        list_next[(i + 1) % TOP_DEPTH] = list_reg[i];
                end
                if (FW'(i) <= fill_reg)
                begin
                    if ((i == 0 || !gt[(i + TOP_DEPTH - 1) % TOP_DEPTH])
                        && (FW'(i) == fill_reg || gt[i]))
                        list_next[i] = ins_entry;
                end
            end
            fill_next = fill_reg + 1'b1;
        end
        else if (ins_en && repl)
        begin
            // smaller entries slide down one slot; the new one lands on the
            // last slot that held a smaller size
            for (int i = 0; i < TOP_DEPTH; i++)
            begin
                if (FW'(i) < fill_reg)
                begin
                    if (FW'(i + 1) < fill_reg && !gt[(i + 1) % TOP_DEPTH]
                        && list_reg[(i + 1) % TOP_DEPTH].size != ins_entry.size)
                        list_next[i] = list_reg[(i + 1) % TOP_DEPTH];
                    else if (list_reg[i].size < ins_entry.size)
                        list_next[i] = ins_entry;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOP_DEPTH; i++)
            list_reg[i] <= list_next[i];
    end

    `ASSERT_IMPL(a_fill_bound, clk, rst_n, fill_reg <= FW'(TOP_DEPTH))
    `ASSERT_IMPL(a_fill_step, clk, rst_n,
        (fill_reg == $past(fill_reg)) || (fill_reg == $past(fill_reg) + 1'b1))
    `ASSERT_IMPL(a_grow_only_on_ins, clk, rst_n, !ins_en |=> $stable(fill_reg))
endmodule

// ===== rtl/top_k_object_tracker.sv =====
// Top level of the top-k object tracker: control sequencer, config regs,
// output register. Depends on tkot_pkg, tkot_if, tkot_hist, tkot_list.
//
// Usage:
//  in_ch  : input words (kind, class id, object size, object tag).
//  out_ch : result words; a report gives one word per list entry, largest
//           first, with last on the final one (one word with entry_valid 0
//           if the list is empty); a class read gives one word.
//  cfg_ch : register writes, index 0 object_limit, 1 highest counted class;
//           always ready. The user must write them only while the block
//           is idle; the block itself does not enforce this.
//  Steps  : a record reads the histogram, then writes it back and inserts
//           into the list; in_ch.ready stays low until the sequencer is idle.
//  Reset  : after rst_n the class memories are cleared one slot a cycle,
//           every slot in turn, while in_ch.ready stays low.
//  Stall  : a result waits in the output register while out_ch.ready is
//           low; the sequencer holds until it is taken.
`timescale 1ns / 1ps
module top_k_object_tracker #(
    parameter int TOP_DEPTH   = tkot_pkg::TopDepthDefault,
    parameter int CLASS_SLOTS = tkot_pkg::ClassSlotsDefault
) (
    input  logic clk,
    input  logic rst_n,
    tkot_in_if.sink    in_ch,
    tkot_out_if.source out_ch,
    tkot_cfg_if.sink   cfg_ch
);
    import tkot_pkg::*;
    localparam int AW = $clog2(CLASS_SLOTS);
    localparam int FW = $clog2(TOP_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RECORD = 4'b0010,
        ST_READ   = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    in_word_t          item_reg;
    logic [LimitW-1:0] limit_reg;
    logic [ClassW-1:0] ccount_reg;
    logic [SeenW-1:0]  seen_reg;
    logic [FW-1:0]     k_reg;
    out_word_t         obuf_reg;
    logic              ovalid_reg;
    logic              hbusy;
    logic [CountW-1:0] h_count;
    logic [BytesW-1:0] h_bytes;
    logic [AW-1:0]     h_addr;
    logic              in_range;
    logic              accept;
    logic              can_emit;
    logic              rd_en;
    logic              upd_en;
    logic              ins_en;
    logic [FW-1:0]     fill;
    logic [FW-1:0]     rd_idx;
    top_entry_t        rd_entry;
    top_entry_t        ins_entry;
    out_word_t         res;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (state_reg == ST_IDLE) && !hbusy;
    assign accept       = in_ch.valid && in_ch.ready;
    assign can_emit     = !ovalid_reg || out_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = obuf_reg;

    // class slot index; ids beyond the memory map are flagged out of range
    assign h_addr   = AW'(in_ch.data.cls_id);
    assign in_range = ({{(32-ClassW){1'b0}}, in_ch.data.cls_id} < CLASS_SLOTS);
    assign rd_en    = accept && in_range
        && (in_ch.data.kind == KIND_RECORD || in_ch.data.kind == KIND_READ);
    assign upd_en   = (state_reg == ST_RECORD) && item_reg.cls_id != '0
        && item_reg.cls_id <= ccount_reg
        && ({{(32-ClassW){1'b0}}, item_reg.cls_id} < CLASS_SLOTS);
    assign ins_en   = (state_reg == ST_RECORD);
    assign ins_entry = '{size: item_reg.object_size, tag: item_reg.obj_tag,
                         cls: item_reg.cls_id};
    assign rd_idx   = fill - 1'b1 - k_reg;

    tkot_hist #(.CLASS_SLOTS(CLASS_SLOTS)) u_hist (
        .clk(clk), .rst_n(rst_n), .rd_en(rd_en), .rd_addr(h_addr),
        .upd_en(upd_en), .upd_size(item_reg.object_size),
        .rd_count(h_count), .rd_bytes(h_bytes), .busy(hbusy)
    );

    tkot_list #(.TOP_DEPTH(TOP_DEPTH)) u_list (
        .clk(clk), .rst_n(rst_n), .ins_en(ins_en), .object_limit(limit_reg),
        .ins_entry(ins_entry), .rd_idx(rd_idx), .rd_entry(rd_entry), .fill(fill)
    );

    // result word for the current sequencer step
    always_comb
    begin
        res = '0;
        res.objects_total = seen_reg;
        if (state_reg == ST_READ)
        begin
            if ({{(32-ClassW){1'b0}}, item_reg.cls_id} < CLASS_SLOTS)
            begin
                res.inst_count = h_count;
                res.byte_total = h_bytes;
            end
            res.last = 1'b1;
        end
        else if (fill == '0)
            res.last = 1'b1;
        else
        begin
            res.entry_valid = 1'b1;
            res.rank        = RankW'(k_reg);
            res.entry_size  = rd_entry.size;
            res.entry_tag   = rd_entry.tag;
            res.entry_class = rd_entry.cls;
            res.last        = (k_reg + 1'b1 == fill);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.data.kind)
                        KIND_RECORD: state_next = ST_RECORD;
                        KIND_REPORT: state_next = ST_REPORT;
                        KIND_READ:   state_next = ST_READ;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RECORD: state_next = ST_IDLE;
            ST_READ:   if (can_emit) state_next = ST_IDLE;
            ST_REPORT: if (can_emit && res.last) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            limit_reg  <= LimitW'(16);
            ccount_reg <= '1;
            seen_reg   <= '0;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.data.index)
                    REG_OBJECT_LIMIT: limit_reg <= cfg_ch.data.data[LimitW-1:0];
                    REG_CLASS_MAX:    ccount_reg <= cfg_ch.data.data[ClassW-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_RECORD && seen_reg != '1)
                seen_reg <= seen_reg + 1'b1;
            if ((state_reg == ST_READ || state_reg == ST_REPORT) && can_emit)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_REPORT && can_emit)
                k_reg <= res.last ? '0 : k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_ch.data;
        if ((state_reg == ST_READ || state_reg == ST_REPORT) && can_emit)
            obuf_reg <= res;
    end
endmodule

// ===== tb/sv/top_k_object_tracker_tb.sv =====
// Self-checking top-k object tracker bench: directed table, register cases, random words.
// Depends on tkot_pkg, tkot_if and the top_k_object_tracker RTL.
`timescale 1ns / 1ps
module top_k_object_tracker_tb;
    import tkot_pkg::*;

    localparam int Depth = 16;
    localparam int Slots = 1024;
    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [BytesW-1:0] BytesMax = '1;
    localparam logic [SeenW-1:0]  SeenMax  = '1;
    localparam logic [KindW-1:0]  KIND_UNUSED = 2'd3;
    localparam longint CycleLimit = 400000;

    logic clk;
    logic rst_n;

    tkot_in_if  in_ch ();
    tkot_out_if out_ch ();
    tkot_cfg_if cfg_ch ();

    top_k_object_tracker u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Predictor state: a mirror of the block's list, histogram and registers.
    top_entry_t        mir_list [Depth];
    int unsigned       mir_fill;
    logic [CountW-1:0] mir_counts [Slots];
    logic [BytesW-1:0] mir_bytes [Slots];
    logic [SeenW-1:0]  mir_seen;
    logic [LimitW-1:0] mir_limit;
    logic [ClassW-1:0] mir_class_max;

    out_word_t pending_results [$];
    int        fail_count;
    longint    cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;

    // Directed table; has_fixed rows carry one hand-written expected word.
    typedef struct {
        in_word_t  word;
        bit        has_fixed;
        out_word_t fixed;
    } table_row_t;
    table_row_t directed [$];

    // Offer an object to the largest-objects list.
    function automatic void offer_object(logic [SizeW-1:0] size, logic [TagW-1:0] tag,
                                         logic [ClassW-1:0] cls);
        int unsigned lim;
        int unsigned i;
        lim = (mir_limit > Depth) ? Depth : mir_limit;
        if (lim == 0)
        begin
            return;
        end
        if (mir_fill < lim)
        begin
            // not full: sort in after equal sizes
            i = mir_fill;
            while (i > 0 && mir_list[i-1].size > size)
            begin
                mir_list[i] = mir_list[i-1];
                i--;
            end
            mir_list[i] = '{size: size, tag: tag, cls: cls};
            mir_fill++;
            return;
        end
        // full (or limit lowered below fill): must beat the smallest strictly
        if (mir_fill == 0 || size <= mir_list[0].size)
        begin
            return;
        end
        i = 0;
        while (i + 1 < mir_fill && mir_list[i+1].size < size)
        begin
            mir_list[i] = mir_list[i+1];
            i++;
        end
        mir_list[i] = '{size: size, tag: tag, cls: cls};
    endfunction

    // Update the mirror for one accepted word and queue its results.
    function automatic void track_word(in_word_t w);
        out_word_t r;
        r = '0;
        r.objects_total = mir_seen;
        case (w.kind)
            KIND_RECORD:
            begin
                if (mir_seen != SeenMax)
                begin
                    mir_seen++;
                end
                if (w.cls_id >= 1 && w.cls_id <= mir_class_max)
                begin
                    if (mir_counts[w.cls_id] != CountMax)
                    begin
                        mir_counts[w.cls_id]++;
                    end
                    if (mir_bytes[w.cls_id] > BytesMax - BytesW'(w.object_size))
                    begin
                        mir_bytes[w.cls_id] = BytesMax;
                    end
                    else
                    begin
                        mir_bytes[w.cls_id] += BytesW'(w.object_size);
                    end
                end
                offer_object(w.object_size, w.obj_tag, w.cls_id);
            end
            KIND_REPORT:
            begin
                if (mir_fill == 0)
                begin
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
                for (int k = 0; k < mir_fill; k++)
                begin
                    r.entry_valid = 1'b1;
                    r.rank        = RankW'(k);
                    r.entry_size  = mir_list[mir_fill-1-k].size;
                    r.entry_tag   = mir_list[mir_fill-1-k].tag;
                    r.entry_class = mir_list[mir_fill-1-k].cls;
                    r.last        = (k + 1 == mir_fill);
                    pending_results.push_back(r);
                end
            end
            KIND_READ:
            begin
                r.inst_count = mir_counts[w.cls_id];
                r.byte_total = mir_bytes[w.cls_id];
                r.last       = 1'b1;
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Result checker: compare every accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t got;
        out_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.entry_valid !== want.entry_valid || got.rank !== want.rank
                    || got.entry_size !== want.entry_size
                    || got.entry_tag !== want.entry_tag
                    || got.entry_class !== want.entry_class
                    || got.inst_count !== want.inst_count
                    || got.byte_total !== want.byte_total
                    || got.objects_total !== want.objects_total
                    || got.last !== want.last)
                begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one word, with random idle cycles ahead of it; valid stays high
    // after the accept so that back-to-back words need one drive per edge.
    task automatic send_word(in_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        track_word(w);
    endtask

    // Wait until every expected word has come, then let the pipeline drain.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, data: value};
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        if (idx == REG_OBJECT_LIMIT)
        begin
            mir_limit = LimitW'(value);
        end
        else
        begin
            mir_class_max = ClassW'(value);
        end
        @(posedge clk);
    endtask

    function automatic in_word_t make_word(logic [KindW-1:0] kind, logic [ClassW-1:0] cid,
                                           logic [SizeW-1:0] size, logic [TagW-1:0] tag);
        in_word_t w;
        w = '{kind: kind, cls_id: cid, object_size: size, obj_tag: tag};
        return w;
    endfunction

    function automatic void add_row(in_word_t w);
        table_row_t row;
        row.word = w;
        row.has_fixed = 1'b0;
        row.fixed = '0;
        directed.push_back(row);
    endfunction

    function automatic void add_fixed_row(in_word_t w, out_word_t fixed);
        table_row_t row;
        row.word = w;
        row.has_fixed = 1'b1;
        row.fixed = fixed;
        directed.push_back(row);
    endfunction

    // Random word: mostly records with sizes drawn to hit ties and extremes.
    function automatic in_word_t random_word();
        in_word_t w;
        int pick;
        w.obj_tag = {$urandom, $urandom};
        w.cls_id  = ($urandom_range(3) == 0) ? ClassW'($urandom) : ClassW'($urandom_range(8));
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            w.object_size = '1;
        end
        else if (pick < 4)
        begin
            w.object_size = SizeW'($urandom_range(6));
        end
        else
        begin
            w.object_size = SizeW'({$urandom, $urandom});
        end
        pick = $urandom_range(99);
        w.kind = (pick < 72) ? KIND_RECORD : (pick < 84) ? KIND_REPORT :
                 (pick < 96) ? KIND_READ : KIND_UNUSED;
        return w;
    endfunction

    initial
    begin
        out_word_t fixed;
        in_word_t  w;

        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        fail_count   = 0;
        cycle_count  = 0;
        send_idle_pct = 31;
        recv_idle_pct = 78;
        mir_fill = 0;
        mir_seen = '0;
        mir_limit = LimitW'(16);
        mir_class_max = ClassW'(1023);
        for (int i = 0; i < Depth; i++)
        begin
            mir_list[i] = '0;
        end
        for (int i = 0; i < Slots; i++)
        begin
            mir_counts[i] = '0;
            mir_bytes[i]  = '0;
        end

        // Directed table: empty report after reset, read of zero stats,
        // extremes of size and tag, ties, class bounds, the unused kind.
        fixed = '0;
        fixed.last = 1'b1;
        add_fixed_row(make_word(KIND_REPORT, '0, '0, '0), fixed);
        add_fixed_row(make_word(KIND_READ, ClassW'(1023), '1, '1), fixed);
        add_row(make_word(KIND_RECORD, ClassW'(1), '1, '1));
        add_row(make_word(KIND_RECORD, ClassW'(1), '1, 64'h1));
        add_row(make_word(KIND_RECORD, '0, '0, '0));
        add_row(make_word(KIND_RECORD, ClassW'(1023), SizeW'(5), 64'hA5A5));
        add_row(make_word(KIND_RECORD, ClassW'(2), SizeW'(5), 64'h5A5A));
        add_row(make_word(KIND_UNUSED, ClassW'(3), SizeW'(9), 64'h9));
        add_row(make_word(KIND_READ, ClassW'(1), '0, '0));
        add_row(make_word(KIND_READ, '0, '0, '0));
        add_row(make_word(KIND_READ, ClassW'(1023), '0, '0));
        add_row(make_word(KIND_REPORT, '0, '0, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].has_fixed)
            begin
                // hand-written value stands in for the predicted one
                send_word(directed[i].word);
                void'(pending_results.pop_back());
                pending_results.push_back(directed[i].fixed);
            end
            else
            begin
                send_word(directed[i].word);
            end
        end
        drain_results();

        // Lowered limit with a full list, then class bound, then list off.
        write_reg(REG_OBJECT_LIMIT, CfgDataW'(2));
        write_reg(REG_CLASS_MAX, CfgDataW'(0));
        send_word(make_word(KIND_RECORD, ClassW'(2), SizeW'(6), 64'h66));
        send_word(make_word(KIND_RECORD, ClassW'(2), SizeW'(5), 64'h55));
        send_word(make_word(KIND_READ, ClassW'(2), '0, '0));
        send_word(make_word(KIND_REPORT, '0, '0, '0));
        drain_results();
        write_reg(REG_OBJECT_LIMIT, CfgDataW'(0));
        send_word(make_word(KIND_RECORD, ClassW'(1), '1, 64'h77));
        send_word(make_word(KIND_REPORT, '0, '0, '0));
        drain_results();

        // Random phases through several register settings and idle mixes.
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_OBJECT_LIMIT,
                      CfgDataW'((phase == 0) ? 31 : (phase == 1) ? 1 : $urandom_range(16)));
            write_reg(REG_CLASS_MAX,
                      CfgDataW'((phase == 2) ? 0 : (phase == 3) ? 4 : 1023));
            if (phase == 2)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 31;
            end
            if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 17; i++)
            begin
                w = random_word();
                send_word(w);
            end
            drain_results();
        end

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
